// ===== design/hst_pkg.sv =====
// Shared types and constants for the handle slot table.
// Used by hst_occ, the top level and the bench; depends on nothing else.
package hst_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int SLOT_IO_W = 6;
    localparam int DATA_IO_W = 32;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_GET    = 2'd2;

    typedef struct packed {
        logic [1:0]           mode;
        logic [SLOT_IO_W-1:0] slot_in;
        logic [DATA_IO_W-1:0] data_in;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_IO_W-1:0] slot_out;
        logic [DATA_IO_W-1:0] data_out;
        logic                 full_res;
    } out_word_t;

    // Update request from the sequencer to the occupancy tracker.
    typedef struct packed {
        logic add_en;
        logic remove_en;
        logic fill;
    } occ_cmd_t;

endpackage

// ===== design/hst_store.sv =====
// Entry store: one synchronous memory with one write and one registered read port.
// Depends on nothing; sized by the parameters handed down from the top level.
module hst_store #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    parameter int SLOT_W     = 6
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [SLOT_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [SLOT_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/hst_occ.sv =====
// Occupancy bitmap and high-water mark, with the encoders for the free slot and new mark.
// Depends on hst_pkg for the update request type.
module hst_occ #(
    parameter int CAPACITY = 64,
    parameter int SLOT_W   = 6,
    parameter int MARK_W   = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hst_pkg::occ_cmd_t   cmd,
    input  logic [SLOT_W-1:0]   idx,
    output logic [SLOT_W-1:0]   add_slot,
    output logic                add_full,
    output logic                occ_at_idx,
    output logic [MARK_W-1:0]   high_water
);

    logic [CAPACITY-1:0] occ_reg;
    logic [CAPACITY-1:0] occ_next;
    logic [MARK_W-1:0]   high_water_reg;
    logic [MARK_W-1:0]   high_water_next;

    logic                at_mark;
    logic                free_found;
    logic [SLOT_W-1:0]   free_slot;
    logic [CAPACITY-1:0] occ_clr;
    logic [MARK_W-1:0]   mark_after;

    assign at_mark = high_water_reg < MARK_W'(CAPACITY);

    // Lowest empty slot from 1 upward; slot 0 is never handed out.
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = CAPACITY - 1; i >= 1; i--)
        begin
            if (!occ_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    assign add_slot   = at_mark ? high_water_reg[SLOT_W-1:0] : free_slot;
    assign add_full   = !at_mark && !free_found;
    assign occ_at_idx = occ_reg[idx];
    assign high_water = high_water_reg;

    // Everything at or above the mark is empty, so after a remove the mark
    // falls to one past the highest occupied slot.
    always_comb
    begin
        occ_clr      = occ_reg;
        occ_clr[idx] = 1'b0;
        mark_after   = MARK_W'(1);
        for (int i = 1; i < CAPACITY; i++)
        begin
            if (occ_clr[i])
            begin
                mark_after = MARK_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        occ_next        = occ_reg;
        high_water_next = high_water_reg;
        if (cmd.add_en && !add_full)
        begin
            occ_next[add_slot] = cmd.fill;
            if (at_mark)
            begin
                high_water_next = high_water_reg + MARK_W'(1);
            end
        end
        else if (cmd.remove_en)
        begin
            occ_next        = occ_clr;
            high_water_next = mark_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= '0;
            high_water_reg <= MARK_W'(1);
        end
        else
        begin
            occ_reg        <= occ_next;
            high_water_reg <= high_water_next;
        end
    end

    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        high_water_reg != '0 && high_water_reg <= MARK_W'(CAPACITY))
        else $error("high-water mark out of range");

    a_slot0_free: assert property (@(posedge clk) disable iff (!rst_n)
        !occ_reg[0])
        else $error("reserved slot marked as occupied");

    a_above_mark_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg >> high_water_reg) == '0)
        else $error("occupied slot at or above the high-water mark");

endmodule

// ===== design/handle_slot_table_unit.sv =====
// Handle slot table: maps data words to small slot numbers with add, remove and get.
// Depends on hst_pkg, hst_store and hst_occ.
//
// A word is accepted in the idle state and worked in the execute state: at
// acceptance the entry store is read at slot_in; in the execute state the
// registered read data, the occupancy bitmap and the high-water mark produce the
// result and the bitmap, mark and store are updated. One word is in work at a
// time; in_ready is high while the table waits for a word, also while a finished
// result sits in the output register. If that result has not been taken, the
// execute state waits for out_ready. Reset clears the occupancy bitmap, so words
// are accepted at once with no clearing pass; an empty slot reads as zero.
module handle_slot_table_unit #(
    parameter int CAPACITY   = hst_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = hst_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hst_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output hst_pkg::out_word_t out_word
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int MARK_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (MARK_W > hst_pkg::SLOT_IO_W) ? MARK_W : hst_pkg::SLOT_IO_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic [1:0]                mode_reg;
    logic [hst_pkg::SLOT_IO_W-1:0] idx_reg;
    logic [DATA_WIDTH-1:0]     data_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    hst_pkg::out_word_t        out_reg;
    hst_pkg::out_word_t        result;

    logic                      accept;
    logic                      exec_go;
    logic                      in_range;
    logic [DATA_WIDTH-1:0]     entry;
    logic [SLOT_W-1:0]         slot_idx;

    hst_pkg::occ_cmd_t         occ_cmd;
    logic [SLOT_W-1:0]         add_slot;
    logic                      add_full;
    logic                      occ_at_idx;
    logic [MARK_W-1:0]         high_water;
    logic [DATA_WIDTH-1:0]     rd_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign exec_go   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign slot_idx  = SLOT_W'(idx_reg);
    assign in_range  = (idx_reg != '0) && (CMP_W'(idx_reg) < CMP_W'(high_water));
    assign entry     = (in_range && occ_at_idx) ? rd_data : '0;

    always_comb
    begin
        occ_cmd.add_en    = exec_go && (mode_reg == hst_pkg::MODE_ADD);
        occ_cmd.remove_en = exec_go && (mode_reg == hst_pkg::MODE_REMOVE) && in_range;
        occ_cmd.fill      = (data_reg != '0);
    end

    always_comb
    begin
        result = '0;
        unique case (mode_reg)
            hst_pkg::MODE_ADD:
            begin
                result.full_res = add_full;
                result.slot_out = add_full ? '0 : hst_pkg::SLOT_IO_W'(add_slot);
            end
            hst_pkg::MODE_REMOVE, hst_pkg::MODE_GET:
            begin
                result.data_out = hst_pkg::DATA_IO_W'(entry);
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    hst_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .SLOT_W     (SLOT_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (occ_cmd.add_en && !add_full),
        .wr_addr (add_slot),
        .wr_data (data_reg),
        .rd_en   (accept),
        .rd_addr (SLOT_W'(in_word.slot_in)),
        .rd_data (rd_data)
    );

    hst_occ #(
        .CAPACITY (CAPACITY),
        .SLOT_W   (SLOT_W),
        .MARK_W   (MARK_W)
    ) u_occ (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (occ_cmd),
        .idx        (slot_idx),
        .add_slot   (add_slot),
        .add_full   (add_full),
        .occ_at_idx (occ_at_idx),
        .high_water (high_water)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= in_word.mode;
            idx_reg  <= in_word.slot_in;
            data_reg <= DATA_WIDTH'(in_word.data_in);
        end
        if (exec_go)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    a_exec_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished word did not reach the output register");

    a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !exec_go) |=> $stable(rd_data))
        else $error("store read data changed while the word was stalled");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.full_res) |-> (out_reg.slot_out == '0
            && out_reg.data_out == '0))
        else $error("full result carries a slot or data");

endmodule

// ===== bench/handle_slot_table_unit_test.sv =====
// Self-checking bench for handle_slot_table_unit: add, remove, get and unused-mode
// words on both handshakes, with results checked against directed expectations or an in-bench slot table.
// Depends on hst_pkg and the handle_slot_table_unit RTL only.
module handle_slot_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = hst_pkg::CAPACITY_DEF;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 2000;
    localparam int LONG_STALL = 300;
    localparam int PRESSURE_AT = 600;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_t;

    typedef struct {
        hst_pkg::in_word_t  word;
        bit                 typed;
        hst_pkg::out_word_t want;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    hst_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_ready;
    hst_pkg::out_word_t out_word;

    // Shadow copy of the table and its high-water mark.
    logic [hst_pkg::DATA_IO_W-1:0] slot_words [TABLE_SLOTS];
    int                            high_mark;

    hst_pkg::out_word_t pending_results[$];
    directed_row_t      directed_rows[$];

    int failures = 0;
    int cycle_count = 0;
    int results_seen = 0;
    int full_seen = 0;
    int peak_mark = 1;
    int mode_count [4] = '{0, 0, 0, 0};
    bit relaxed = 1'b0;
    bit hold_request = 1'b0;
    bit pressure_asked = 1'b0;
    int long_stall_cycles = 0;

    handle_slot_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one word to the shadow table and returns the result it must give.
    function automatic hst_pkg::out_word_t apply_table_op(input hst_pkg::in_word_t w);
        hst_pkg::out_word_t r;
        bit                 placed;
        r = '0;
        placed = 1'b0;
        case (w.mode)
            hst_pkg::MODE_ADD:
            begin
                if (high_mark < TABLE_SLOTS)
                begin
                    slot_words[high_mark] = w.data_in;
                    r.slot_out = hst_pkg::SLOT_IO_W'(high_mark);
                    high_mark++;
                end
                else
                begin
                    for (int c = 1; c < TABLE_SLOTS; c++)
                    begin
                        if (!placed && slot_words[c] == '0)
                        begin
                            slot_words[c] = w.data_in;
                            r.slot_out = hst_pkg::SLOT_IO_W'(c);
                            placed = 1'b1;
                        end
                    end
                    r.full_res = !placed;
                end
            end
            hst_pkg::MODE_REMOVE:
            begin
                if (w.slot_in != 0 && int'(w.slot_in) < high_mark)
                begin
                    r.data_out = slot_words[w.slot_in];
                    slot_words[w.slot_in] = '0;
                    // Trailing empty slots no longer count towards the mark.
                    while (high_mark > 1 && slot_words[high_mark - 1] == '0)
                        high_mark--;
                end
            end
            hst_pkg::MODE_GET:
            begin
                if (w.slot_in != 0 && int'(w.slot_in) < high_mark)
                    r.data_out = slot_words[w.slot_in];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] mode, input logic [5:0] slot,
                                    input logic [31:0] data, input bit typed,
                                    input logic [5:0] want_slot, input logic [31:0] want_data,
                                    input logic want_full);
        directed_row_t row;
        row.word.mode = mode;
        row.word.slot_in = slot;
        row.word.data_in = data;
        row.typed = typed;
        row.want.slot_out = want_slot;
        row.want.data_out = want_data;
        row.want.full_res = want_full;
        directed_rows.push_back(row);
    endfunction

    // Most slot numbers fall below the mark, often right at its top entry.
    function automatic hst_pkg::in_word_t random_word(input burst_kind_t kind);
        hst_pkg::in_word_t w;
        int                roll;
        roll = $urandom_range(0, 99);
        case (kind)
            BURST_FILL:
                w.mode = (roll < 85) ? hst_pkg::MODE_ADD :
                         (roll < 93) ? hst_pkg::MODE_REMOVE : hst_pkg::MODE_GET;
            BURST_DRAIN:
                w.mode = (roll < 70) ? hst_pkg::MODE_REMOVE :
                         (roll < 85) ? hst_pkg::MODE_ADD : hst_pkg::MODE_GET;
            default:
                w.mode = (roll < 35) ? hst_pkg::MODE_ADD :
                         (roll < 65) ? hst_pkg::MODE_REMOVE :
                         (roll < 96) ? hst_pkg::MODE_GET : MODE_UNUSED;
        endcase
        roll = $urandom_range(0, 9);
        if (high_mark > 1 && roll < 2)
            w.slot_in = hst_pkg::SLOT_IO_W'(high_mark - 1);
        else if (high_mark > 1 && roll < 8)
            w.slot_in = hst_pkg::SLOT_IO_W'($urandom_range(1, high_mark - 1));
        else
            w.slot_in = hst_pkg::SLOT_IO_W'($urandom_range(0, 63));
        roll = $urandom_range(0, 19);
        w.data_in = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input hst_pkg::in_word_t w, input bit typed,
                             input hst_pkg::out_word_t want);
        int                 gap;
        hst_pkg::out_word_t predicted;
        gap = relaxed ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_table_op(w);
        pending_results.push_back(typed ? want : predicted);
        mode_count[w.mode]++;
        if (high_mark > peak_mark)
            peak_mark = high_mark;
        @(negedge clk);
    endtask

    initial
    begin
        int          sent;
        int          burst_len;
        burst_kind_t kind;
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        rst_n = 1'b0;
        foreach (slot_words[i])
            slot_words[i] = '0;
        high_mark = 1;

        add_row(hst_pkg::MODE_GET,    6'd0,  32'h0000_0000, 1, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_GET,    6'd5,  32'h0000_0000, 1, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_REMOVE, 6'd0,  32'h0000_0000, 1, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_REMOVE, 6'd63, 32'h0000_0000, 1, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_ADD,    6'd0,  32'hFFFF_FFFF, 1, 6'd1, 32'h0000_0000, 1'b0);
        // A zero word still claims the slot at the mark.
        add_row(hst_pkg::MODE_ADD,    6'd63, 32'h0000_0000, 1, 6'd2, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_ADD,    6'd0,  32'h0000_0001, 1, 6'd3, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_GET,    6'd1,  32'h0000_0000, 1, 6'd0, 32'hFFFF_FFFF, 1'b0);
        add_row(hst_pkg::MODE_GET,    6'd2,  32'h0000_0000, 1, 6'd0, 32'h0000_0000, 1'b0);
        add_row(MODE_UNUSED,          6'd63, 32'hFFFF_FFFF, 1, 6'd0, 32'h0000_0000, 1'b0);
        // Removing the top entry pulls the mark down past the empty slot below it.
        add_row(hst_pkg::MODE_REMOVE, 6'd3,  32'h0000_0000, 1, 6'd0, 32'h0000_0001, 1'b0);
        add_row(hst_pkg::MODE_GET,    6'd2,  32'h0000_0000, 1, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_ADD,    6'd0,  32'h8000_0000, 1, 6'd2, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_ADD,    6'd0,  32'h7FFF_FFFF, 0, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_ADD,    6'd0,  32'h1234_5678, 0, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_REMOVE, 6'd2,  32'h0000_0000, 1, 6'd0, 32'h8000_0000, 1'b0);
        add_row(hst_pkg::MODE_GET,    6'd2,  32'h0000_0000, 1, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_ADD,    6'd0,  32'h0000_FFFF, 0, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_REMOVE, 6'd0,  32'hFFFF_FFFF, 1, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_GET,    6'd63, 32'hFFFF_FFFF, 1, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_REMOVE, 6'd5,  32'h0000_0000, 0, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_GET,    6'd4,  32'h0000_0000, 0, 6'd0, 32'h0000_0000, 1'b0);
        add_row(hst_pkg::MODE_REMOVE, 6'd1,  32'h0000_0000, 1, 6'd0, 32'hFFFF_FFFF, 1'b0);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        // Open with a long run of adds so that the table fills and reports full early.
        sent = 0;
        kind = BURST_FILL;
        burst_len = 90;
        while (sent < RANDOM_WORDS)
        begin
            relaxed = ($urandom_range(0, 3) == 0);
            if (!pressure_asked && sent >= PRESSURE_AT)
            begin
                pressure_asked = 1'b1;
                hold_request = 1'b1;
                relaxed = 1'b1;
            end
            repeat (burst_len)
            begin
                send_word(random_word(kind), 1'b0, '0);
                sent++;
            end
            kind = burst_kind_t'($urandom_range(0, 2));
            burst_len = $urandom_range(20, 80);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d adds, %0d removes, %0d gets and %0d unused words; %0d checked.",
                 mode_count[hst_pkg::MODE_ADD], mode_count[hst_pkg::MODE_REMOVE],
                 mode_count[hst_pkg::MODE_GET], mode_count[MODE_UNUSED], results_seen);
        $display("Mark peaked at %0d, full reported %0d times, output held off once for %0d cycles.",
                 peak_mark, full_seen, long_stall_cycles);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random hold-offs, one long one on request, and the checks.
    initial
    begin
        int                 stall;
        hst_pkg::out_word_t want;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = relaxed ? 0 : $urandom_range(0, 15);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_STALL;
                long_stall_cycles = LONG_STALL;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_seen++;
            if (out_word.full_res === 1'b1)
                full_seen++;
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected word, got slot %0d data %h full %b", $time,
                         out_word.slot_out, out_word.data_out, out_word.full_res);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_word.slot_out !== want.slot_out)
                begin
                    failures++;
                    $display("%0t: slot_out expected %0d got %0d", $time,
                             want.slot_out, out_word.slot_out);
                end
                if (out_word.data_out !== want.data_out)
                begin
                    failures++;
                    $display("%0t: data_out expected %h got %h", $time,
                             want.data_out, out_word.data_out);
                end
                if (out_word.full_res !== want.full_res)
                begin
                    failures++;
                    $display("%0t: full_res expected %b got %b", $time,
                             want.full_res, out_word.full_res);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timed out after %0d cycles", $time, cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
